// File: rtl/rrd_pkg.sv
// shared types and constants for the response record deframer
`default_nettype none

package rrd_pkg;

    localparam int ByteW     = 8;
    localparam int LenW      = 16;
    localparam int PosW      = 17;
    localparam int StatusW   = 32;
    localparam int HdrIdxW   = 3;
    localparam int OutDataW  = 48;

    localparam logic [ByteW-1:0] TYPE_END_REQUEST = 8'd3;
    localparam logic [ByteW-1:0] TYPE_STDOUT      = 8'd6;
    localparam logic [ByteW-1:0] TYPE_STDERR      = 8'd7;

    localparam logic [HdrIdxW-1:0] HDR_TYPE     = 3'd1;
    localparam logic [HdrIdxW-1:0] HDR_LEN_HI   = 3'd4;
    localparam logic [HdrIdxW-1:0] HDR_LEN_LO   = 3'd5;
    localparam logic [HdrIdxW-1:0] HDR_PAD      = 3'd6;
    localparam logic [HdrIdxW-1:0] HDR_RESERVED = 3'd7;

    localparam logic [PosW-1:0] STATUS_BYTES = 17'd4;
    localparam logic [LenW-1:0] END_BODY_MIN = 16'd8;

    typedef enum logic [1:0] {
        KIND_STDOUT = 2'd0,
        KIND_STDERR = 2'd1,
        KIND_ENDED  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ByteW-1:0]   out_byte;
        logic               last_in_record;
        logic [StatusW-1:0] app_status;
        logic [ByteW-1:0]   protocol_status;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/rrd_parser.sv
// record header collection, body counting and result formation
`default_nettype none

module rrd_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            in_byte,
    output logic                       res_valid,
    output rrd_pkg::result_t           res
);
    import rrd_pkg::*;

    logic                in_body_reg, in_body_next;
    logic [HdrIdxW-1:0]  hdr_idx_reg, hdr_idx_next;
    logic [ByteW-1:0]    rec_type_reg, rec_type_next;
    logic [LenW-1:0]     content_len_reg, content_len_next;
    logic [ByteW-1:0]    pad_len_reg, pad_len_next;
    logic [PosW-1:0]     body_pos_reg, body_pos_next;
    logic [StatusW-1:0]  status_reg, status_next;
    logic [ByteW-1:0]    proto_reg, proto_next;

    logic [PosW-1:0]     pos_inc;
    logic [PosW-1:0]     total;
    logic [PosW-1:0]     content_ext;
    logic                is_content;
    logic                body_done;

    assign content_ext = {1'b0, content_len_reg};
    assign total       = content_ext + {{(PosW-ByteW){1'b0}}, pad_len_reg};
    assign pos_inc     = body_pos_reg + 1'b1;
    assign is_content  = body_pos_reg < content_ext;
    assign body_done   = pos_inc >= total;

    always_comb
    begin
        in_body_next     = in_body_reg;
        hdr_idx_next     = hdr_idx_reg;
        rec_type_next    = rec_type_reg;
        content_len_next = content_len_reg;
        pad_len_next     = pad_len_reg;
        body_pos_next    = body_pos_reg;
        status_next      = status_reg;
        proto_next       = proto_reg;
        if (step)
        begin
            if (!in_body_reg)
            begin
                unique case (hdr_idx_reg)
                    HDR_TYPE:   rec_type_next = in_byte;
                    HDR_LEN_HI: content_len_next = {in_byte, content_len_reg[7:0]};
                    HDR_LEN_LO: content_len_next = {content_len_reg[15:8], in_byte};
                    HDR_PAD:    pad_len_next = in_byte;
                    default:    ;
                endcase
                if (hdr_idx_reg == HDR_RESERVED)
                begin
                    hdr_idx_next  = '0;
                    body_pos_next = '0;
                    status_next   = '0;
                    proto_next    = '0;
                    in_body_next  = (total != '0);
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                end
            end
            else
            begin
                if (is_content && rec_type_reg == TYPE_END_REQUEST)
                begin
                    if (body_pos_reg < STATUS_BYTES)
                        status_next = {status_reg[StatusW-ByteW-1:0], in_byte};
                    else if (body_pos_reg == STATUS_BYTES)
                        proto_next = in_byte;
                end
                body_pos_next = pos_inc;
                if (body_done)
                    in_body_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        if (step && in_body_reg)
        begin
            if (is_content && (rec_type_reg == TYPE_STDOUT || rec_type_reg == TYPE_STDERR))
            begin
                res_valid          = 1'b1;
                res.kind           = (rec_type_reg == TYPE_STDOUT) ? KIND_STDOUT : KIND_STDERR;
                res.out_byte       = in_byte;
                res.last_in_record = (pos_inc == content_ext);
            end
            else if (body_done && rec_type_reg == TYPE_END_REQUEST
                     && content_len_reg >= END_BODY_MIN)
            begin
                res_valid           = 1'b1;
                res.kind            = KIND_ENDED;
                res.app_status      = status_reg;
                res.protocol_status = proto_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg     <= 1'b0;
            hdr_idx_reg     <= '0;
            rec_type_reg    <= '0;
            content_len_reg <= '0;
            pad_len_reg     <= '0;
            body_pos_reg    <= '0;
            status_reg      <= '0;
            proto_reg       <= '0;
        end
        else
        begin
            in_body_reg     <= in_body_next;
            hdr_idx_reg     <= hdr_idx_next;
            rec_type_reg    <= rec_type_next;
            content_len_reg <= content_len_next;
            pad_len_reg     <= pad_len_next;
            body_pos_reg    <= body_pos_next;
            status_reg      <= status_next;
            proto_reg       <= proto_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rrd_out_buf.sv
// result register with skid stage
`default_nettype none

module rrd_out_buf (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  res_valid,
    input  wire rrd_pkg::result_t      res,
    output logic                       room,
    output logic                       out_valid,
    output rrd_pkg::result_t           out_res,
    input  wire logic                  out_ready
);
    import rrd_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    take;

    assign take      = out_valid_reg && out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

// File: rtl/response_record_deframer.sv
// top level of the response record deframer
//
// takes the response byte stream on the s_axis group, one byte per item,
// and gives content bytes and request-ended items on the m_axis group
// tuser carries the kind (stdout byte, stderr byte, request ended),
// tlast marks the last content byte of a record
// each input byte is held in an input register, parsed against the record
// state once the skid stage is empty, and the result lands in an output register
// m_axis_tvalid comes from the output register, not from the parser directly
// throughput: one byte per cycle while the skid stage is empty
// header, padding and ignored record bytes are consumed without output
// reset clears the record state and all three valid flags; the first byte
// after reset is taken as the first header byte
// when the receiver stalls, one extra result is caught in a skid stage;
// s_axis_tready then falls while a byte waits in the input register, and comes from registers only
`default_nettype none

module response_record_deframer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // in_byte
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [rrd_pkg::OutDataW-1:0]       m_axis_tdata,   // out_byte, app_status, protocol_status
    output logic [1:0]                         m_axis_tuser,   // kind
    output logic                               m_axis_tlast    // last_in_record
);
    import rrd_pkg::*;

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             room;
    logic             step;
    logic             res_valid;
    result_t          res;
    result_t          out_res;

    assign step          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    rrd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .in_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    rrd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_res.protocol_status, out_res.app_status, out_res.out_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last_in_record;

endmodule

`default_nettype wire
